>>> design/flpi_pkg.sv
`timescale 1ns / 1ps
// Package for the FIFO lock with priority inheritance.
// Types, codes and the priority compare shared by the waiter cells and the top level.
package flpi_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int DL_BITS     = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic [DL_BITS-1:0] t_dl;
    typedef logic [CNT_W-1:0]   t_cnt;

    localparam logic [1:0] KIND_LOCK   = 2'd0;
    localparam logic [1:0] KIND_UNLOCK = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_QUEUED    = 3'd1;
    localparam logic [2:0] STAT_NOT_RT    = 3'd2;
    localparam logic [2:0] STAT_NESTED    = 3'd3;
    localparam logic [2:0] STAT_NOT_OWNER = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;

    // control from the top level to one waiter cell
    typedef struct packed {
        logic load;
        logic shift;
        logic live;
    } t_cell_ctl;

    // best-so-far token that walks down the cell row during a rescan
    typedef struct packed {
        logic go;
        logic present;
        t_id  id;
        t_dl  dl;
    } t_scan;

    // earlier deadline wins, lower id breaks a tie
    function automatic logic outranks(input t_dl da, input t_id ia, input t_dl db,
                                      input t_id ib);
        return (da < db) || ((da == db) && (ia < ib));
    endfunction

endpackage

>>> design/flpi_cell.sv
`timescale 1ns / 1ps
// One waiter cell: holds one queue entry and one stage of the rescan token.
// Depends on flpi_pkg.
module flpi_cell import flpi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_id       i_skip_id,
    input  t_id       i_new_id,
    input  t_dl       i_new_dl,
    input  t_id       i_nb_id,
    input  t_dl       i_nb_dl,
    input  t_scan     i_scan,
    output t_id       o_id,
    output t_dl       o_dl,
    output t_scan     o_scan
);

    t_id   r_id;
    t_dl   r_dl;
    t_scan r_scan;
    t_id   n_id;
    t_dl   n_dl;
    t_scan n_scan;
    logic  w_take;

    always_comb begin
        n_id = r_id;
        n_dl = r_dl;
        if (i_ctl.shift) begin
            n_id = i_nb_id;
            n_dl = i_nb_dl;
        end else if (i_ctl.load) begin
            n_id = i_new_id;
            n_dl = i_new_dl;
        end
    end

    assign w_take = i_scan.go && i_ctl.live && (r_id != i_skip_id) &&
                    (!i_scan.present || outranks(r_dl, r_id, i_scan.dl, i_scan.id));

    always_comb begin
        n_scan = i_scan;
        if (w_take) begin
            n_scan.present = 1'b1;
            n_scan.id      = r_id;
            n_scan.dl      = r_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        r_dl <= n_dl;
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_id   = r_id;
    assign o_dl   = r_dl;
    assign o_scan = r_scan;

endmodule

>>> design/fifo_lock_priority_inheritance.sv
`timescale 1ns / 1ps
// FIFO lock with priority inheritance: owner state, waiter cell row, result register.
// Depends on flpi_pkg and flpi_cell.
// The result is registered; back-to-back items when output is taken, except while a rescan runs.
// A handoff to the top waiter rescans the cell row; no accept is taken meanwhile.
// Reset (synchronous, active low) empties the queue, drops the owner and the top waiter.
module fifo_lock_priority_inheritance import flpi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  t_id        i_task_id,
    input  t_dl        i_deadline,
    input  logic       i_is_rt,
    input  logic       i_holds_other,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic       o_owner_valid,
    output t_id        o_owner_task,
    output logic       o_wake_valid,
    output t_id        o_wake_task,
    output logic       o_inherit_set,
    output t_dl        o_inherit_deadline,
    output t_id        o_inherit_from,
    output logic       o_clear_inherit,
    output logic       o_hp_valid,
    output t_id        o_hp_task
);

    typedef enum logic {ST_IDLE, ST_SCAN} t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_own_v, n_own_v;
    t_id    r_own_id, n_own_id;
    t_dl    r_eff_dl, n_eff_dl;
    t_id    r_eff_id, n_eff_id;
    logic   r_inh, n_inh;
    logic   r_top_v, n_top_v;
    t_id    r_top_id, n_top_id;
    t_dl    r_top_dl, n_top_dl;
    logic   r_inject, n_inject;
    logic   r_pend_clr, n_pend_clr;

    logic       r_out_valid, n_out_valid;
    logic [2:0] r_status, n_status;
    logic       r_owner_v, n_owner_v;
    t_id        r_owner_t, n_owner_t;
    logic       r_wake_v, n_wake_v;
    t_id        r_wake_t, n_wake_t;
    logic       r_inh_set, n_inh_set;
    t_dl        r_inh_dl, n_inh_dl;
    t_id        r_inh_from, n_inh_from;
    logic       r_clr, n_clr;
    logic       r_hp_v, n_hp_v;
    t_id        r_hp_t, n_hp_t;

    logic  w_acc;
    logic  w_enq;
    logic  w_shift;
    t_id   w_cell_id [QUEUE_DEPTH];
    t_dl   w_cell_dl [QUEUE_DEPTH];
    t_scan w_scan    [QUEUE_DEPTH];
    t_scan w_scan_in;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_scan_in = '{go: r_inject, present: 1'b0, id: '0, dl: '0};

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
            t_cell_ctl w_ctl;
            t_id       w_nb_id;
            t_dl       w_nb_dl;

            assign w_ctl.load  = w_enq && (r_count[IDX_W-1:0] == IDX_W'(k));
            assign w_ctl.shift = w_shift;
            assign w_ctl.live  = (CNT_W'(k) < r_count);

            if (k == QUEUE_DEPTH - 1) begin : g_last
                assign w_nb_id = '0;
                assign w_nb_dl = '0;
            end else begin : g_mid
                assign w_nb_id = w_cell_id[k+1];
                assign w_nb_dl = w_cell_dl[k+1];
            end

            flpi_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_skip_id (r_own_id),
                .i_new_id  (i_task_id),
                .i_new_dl  (i_deadline),
                .i_nb_id   (w_nb_id),
                .i_nb_dl   (w_nb_dl),
                .i_scan    ((k == 0) ? w_scan_in : w_scan[(k == 0) ? 0 : k-1]),
                .o_id      (w_cell_id[k]),
                .o_dl      (w_cell_dl[k]),
                .o_scan    (w_scan[k])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_own_v    = r_own_v;
        n_own_id   = r_own_id;
        n_eff_dl   = r_eff_dl;
        n_eff_id   = r_eff_id;
        n_inh      = r_inh;
        n_top_v    = r_top_v;
        n_top_id   = r_top_id;
        n_top_dl   = r_top_dl;
        n_inject   = 1'b0;
        n_pend_clr = r_pend_clr;
        w_enq      = 1'b0;
        w_shift    = 1'b0;

        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_owner_v   = r_owner_v;
        n_owner_t   = r_owner_t;
        n_wake_v    = r_wake_v;
        n_wake_t    = r_wake_t;
        n_inh_set   = r_inh_set;
        n_inh_dl    = r_inh_dl;
        n_inh_from  = r_inh_from;
        n_clr       = r_clr;
        n_hp_v      = r_hp_v;
        n_hp_t      = r_hp_t;

        if (r_state == ST_SCAN) begin
            if (w_scan[QUEUE_DEPTH-1].go) begin
                n_state     = ST_IDLE;
                n_top_v     = w_scan[QUEUE_DEPTH-1].present;
                n_top_id    = w_scan[QUEUE_DEPTH-1].present ? w_scan[QUEUE_DEPTH-1].id : '0;
                n_top_dl    = w_scan[QUEUE_DEPTH-1].present ? w_scan[QUEUE_DEPTH-1].dl : '0;
                n_out_valid = 1'b1;
                n_status    = STAT_OK;
                n_owner_v   = 1'b1;
                n_owner_t   = r_own_id;
                n_wake_v    = 1'b1;
                n_wake_t    = r_own_id;
                n_inh_set   = 1'b0;
                n_inh_dl    = '0;
                n_inh_from  = '0;
                n_clr       = r_pend_clr;
                n_hp_v      = n_top_v;
                n_hp_t      = n_top_id;
            end
        end else if (w_acc) begin
            n_out_valid = 1'b1;
            n_status    = STAT_OK;
            n_wake_v    = 1'b0;
            n_wake_t    = '0;
            n_inh_set   = 1'b0;
            n_inh_dl    = '0;
            n_inh_from  = '0;
            n_clr       = 1'b0;
            case (i_kind)
                KIND_LOCK: begin
                    if (!i_is_rt) begin
                        n_status = STAT_NOT_RT;
                    end else if (i_holds_other) begin
                        n_status = STAT_NESTED;
                    end else if (!r_own_v) begin
                        n_own_v  = 1'b1;
                        n_own_id = i_task_id;
                        n_eff_dl = i_deadline;
                        n_eff_id = i_task_id;
                        n_inh    = 1'b0;
                    end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_enq    = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_status = STAT_QUEUED;
                        if (!r_top_v || outranks(i_deadline, i_task_id, r_top_dl, r_top_id)) begin
                            n_top_v  = 1'b1;
                            n_top_id = i_task_id;
                            n_top_dl = i_deadline;
                            if (outranks(i_deadline, i_task_id, r_eff_dl, r_eff_id)) begin
                                n_eff_dl   = i_deadline;
                                n_eff_id   = i_task_id;
                                n_inh      = 1'b1;
                                n_inh_set  = 1'b1;
                                n_inh_dl   = i_deadline;
                                n_inh_from = i_task_id;
                            end
                        end
                    end
                end
                KIND_UNLOCK, KIND_CLOSE: begin
                    if (!r_own_v || (r_own_id != i_task_id)) begin
                        n_status = (i_kind == KIND_UNLOCK) ? STAT_NOT_OWNER : STAT_OK;
                    end else begin
                        n_clr = r_inh;
                        if (r_count != '0) begin
                            w_shift  = 1'b1;
                            n_count  = r_count - 1'b1;
                            n_own_id = w_cell_id[0];
                            n_wake_v = 1'b1;
                            n_wake_t = w_cell_id[0];
                            if (r_top_v && (r_top_id == w_cell_id[0]) &&
                                (r_top_dl == w_cell_dl[0])) begin
                                n_eff_dl    = w_cell_dl[0];
                                n_eff_id    = w_cell_id[0];
                                n_inh       = 1'b0;
                                n_state     = ST_SCAN;
                                n_inject    = 1'b1;
                                n_pend_clr  = r_inh;
                                n_out_valid = 1'b0;
                            end else begin
                                n_eff_dl   = r_top_dl;
                                n_eff_id   = r_top_id;
                                n_inh      = 1'b1;
                                n_inh_set  = 1'b1;
                                n_inh_dl   = r_top_dl;
                                n_inh_from = r_top_id;
                            end
                        end else begin
                            n_own_v  = 1'b0;
                            n_own_id = '0;
                            n_eff_dl = '0;
                            n_eff_id = '0;
                            n_inh    = 1'b0;
                        end
                    end
                end
                default: begin
                    n_status = STAT_OK;
                end
            endcase
            n_owner_v = n_own_v;
            n_owner_t = n_own_v ? n_own_id : '0;
            n_hp_v    = n_top_v;
            n_hp_t    = n_top_v ? n_top_id : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_own_v     <= 1'b0;
            r_own_id    <= '0;
            r_eff_dl    <= '0;
            r_eff_id    <= '0;
            r_inh       <= 1'b0;
            r_top_v     <= 1'b0;
            r_top_id    <= '0;
            r_top_dl    <= '0;
            r_inject    <= 1'b0;
            r_pend_clr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_own_v     <= n_own_v;
            r_own_id    <= n_own_id;
            r_eff_dl    <= n_eff_dl;
            r_eff_id    <= n_eff_id;
            r_inh       <= n_inh;
            r_top_v     <= n_top_v;
            r_top_id    <= n_top_id;
            r_top_dl    <= n_top_dl;
            r_inject    <= n_inject;
            r_pend_clr  <= n_pend_clr;
            r_out_valid <= n_out_valid;
        end
        r_status   <= n_status;
        r_owner_v  <= n_owner_v;
        r_owner_t  <= n_owner_t;
        r_wake_v   <= n_wake_v;
        r_wake_t   <= n_wake_t;
        r_inh_set  <= n_inh_set;
        r_inh_dl   <= n_inh_dl;
        r_inh_from <= n_inh_from;
        r_clr      <= n_clr;
        r_hp_v     <= n_hp_v;
        r_hp_t     <= n_hp_t;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_owner_valid      = r_owner_v;
    assign o_owner_task       = r_owner_t;
    assign o_wake_valid       = r_wake_v;
    assign o_wake_task        = r_wake_t;
    assign o_inherit_set      = r_inh_set;
    assign o_inherit_deadline = r_inh_dl;
    assign o_inherit_from     = r_inh_from;
    assign o_clear_inherit    = r_clr;
    assign o_hp_valid         = r_hp_v;
    assign o_hp_task          = r_hp_t;

endmodule
